[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/sfcs_pkg.sv]
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Bus action codes, flash opcodes, slot table and job type.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // Addressing
  localparam int unsigned ADDRESS_BITS = 24;
  localparam int unsigned PAGE_BYTES   = 256;   // power of two
  localparam int unsigned MEM_BITS     = (ADDRESS_BITS > 24) ? 24 : ADDRESS_BITS;
  localparam int unsigned NA_W         = 25;
  localparam logic [NA_W-1:0] MEM_END   = NA_W'(1) << MEM_BITS;
  localparam logic [NA_W-1:0] PAGE_MASK = NA_W'(PAGE_BYTES - 1);

  // Bus actions
  typedef enum logic [1:0] {
    ACT_SEND     = 2'd0,
    ACT_RECV     = 2'd1,
    ACT_DESELECT = 2'd2,
    ACT_POLL     = 2'd3
  } act_e;

  // Flash opcodes
  localparam logic [7:0] OP_EWSR     = 8'h50;
  localparam logic [7:0] OP_WRSR     = 8'h01;
  localparam logic [7:0] SR_UNLOCKED = 8'h00;
  localparam logic [7:0] OP_WREN     = 8'h06;
  localparam logic [7:0] OP_ERASE    = 8'h60;
  localparam logic [7:0] OP_PROGRAM  = 8'h02;
  localparam logic [7:0] OP_READ     = 8'h03;
  localparam logic [7:0] OP_WRDI     = 8'h04;

  // Where a sent byte comes from
  typedef enum logic [2:0] {
    SRC_CONST = 3'd0,
    SRC_ADDR_HI = 3'd1,
    SRC_ADDR_MID = 3'd2,
    SRC_ADDR_LO = 3'd3,
    SRC_DATA = 3'd4
  } src_e;

  typedef struct packed {
    act_e       action;
    src_e       src;
    logic [7:0] value;
  } slot_t;

  // Slot numbering: fixed emission order of every possible action
  localparam int unsigned SLOTS       = 31;
  localparam int unsigned SLOT_IDX_W  = $clog2(SLOTS);
  localparam int unsigned SL_ABANDON  = 0;   // deselect, poll
  localparam int unsigned SL_WSTART   = 2;   // ten actions
  localparam int unsigned SL_RSTART   = 12;  // four actions
  localparam int unsigned SL_POPEN    = 16;  // six actions
  localparam int unsigned SL_WDATA    = 22;
  localparam int unsigned SL_RECV     = 23;
  localparam int unsigned SL_PAGE_END = 24;  // deselect, poll
  localparam int unsigned SL_WCLOSE   = 26;  // deselect, poll
  localparam int unsigned SL_WDIS     = 28;  // send 04, deselect
  localparam int unsigned SL_RCLOSE   = 30;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [23:0]      addr;
    logic [7:0]       data;
  } job_t;

  function automatic slot_t slot_info(input logic [SLOT_IDX_W-1:0] idx);
    slot_t s;
    s = '{action: ACT_DESELECT, src: SRC_CONST, value: 8'h00};
    case (idx)
      5'd0:  s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd1:  s = '{ACT_POLL,     SRC_CONST, 8'h00};
      5'd2:  s = '{ACT_SEND,     SRC_CONST, OP_EWSR};
      5'd3:  s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd4:  s = '{ACT_SEND,     SRC_CONST, OP_WRSR};
      5'd5:  s = '{ACT_SEND,     SRC_CONST, SR_UNLOCKED};
      5'd6:  s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd7:  s = '{ACT_SEND,     SRC_CONST, OP_WREN};
      5'd8:  s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd9:  s = '{ACT_SEND,     SRC_CONST, OP_ERASE};
      5'd10: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd11: s = '{ACT_POLL,     SRC_CONST, 8'h00};
      5'd12: s = '{ACT_SEND,     SRC_CONST, OP_READ};
      5'd13: s = '{ACT_SEND,     SRC_ADDR_HI, 8'h00};
      5'd14: s = '{ACT_SEND,     SRC_ADDR_MID, 8'h00};
      5'd15: s = '{ACT_SEND,     SRC_ADDR_LO, 8'h00};
      5'd16: s = '{ACT_SEND,     SRC_CONST, OP_WREN};
      5'd17: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd18: s = '{ACT_SEND,     SRC_CONST, OP_PROGRAM};
      5'd19: s = '{ACT_SEND,     SRC_ADDR_HI, 8'h00};
      5'd20: s = '{ACT_SEND,     SRC_ADDR_MID, 8'h00};
      5'd21: s = '{ACT_SEND,     SRC_ADDR_LO, 8'h00};
      5'd22: s = '{ACT_SEND,     SRC_DATA, 8'h00};
      5'd23: s = '{ACT_RECV,     SRC_CONST, 8'h00};
      5'd24: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd25: s = '{ACT_POLL,     SRC_CONST, 8'h00};
      5'd26: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd27: s = '{ACT_POLL,     SRC_CONST, 8'h00};
      5'd28: s = '{ACT_SEND,     SRC_CONST, OP_WRDI};
      5'd29: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      5'd30: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
      default: s = '{ACT_DESELECT, SRC_CONST, 8'h00};
    endcase
    return s;
  endfunction

endpackage

[hdl/spi_flash_command_sequencer_core.sv]
// ----------------------------------------------------------------------------
// SPI flash command sequencer core
// Turns host request words into a stream of SPI flash bus actions.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one word per host data byte (mode, first, address, data,
//   final_req). Output channel: one word per bus action (action, byte_value,
//   run_end); run_end marks the last action caused by an input word.
//   Both channels move a word when valid is high and stall is low.
// Flow
//   The sequencing state (address, request and frame flags) is updated in the
//   cycle a word is taken, and the actions it causes are held as a job mask
//   in a one-word queue. The emitter hands out one action per cycle while the
//   output is not stalled; a word causes 1 to 23 actions, registered from the
//   queue via the emitter mask into the output register. A word causing no
//   action never enters the queue. The one-word queue lets the next word be
//   taken while the emitter is busy; in_stall_o rises only while it is full.
// Reset
//   Clears the request state and empties the queue, emitter and output.
// Stall
//   A stalled output holds its word; the emitter and then the queue fill
//   and in_stall_o holds further input back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_flash_command_sequencer_core
  import sfcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        first_i,
  input  logic [23:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        final_req_i,
  // action channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  byte_value_o,
  output logic        run_end_o
);

  // Sequencing state
  logic [NA_W-1:0] na_q, na_d;
  logic            active_q, active_d;
  logic            frame_q, frame_d;
  logic            mode_q, mode_d;

  // Job queue and emitter
  logic             pend_valid_q, pend_valid_d;
  job_t             pend_q, job_new;
  logic [SLOTS-1:0] cur_mask_q, cur_mask_d;
  logic [23:0]      cur_addr_q;
  logic [7:0]       cur_data_q;

  // Output register
  logic       out_valid_q, out_valid_d;
  act_e       out_act_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;

  logic in_take;
  assign in_take    = in_valid_i && !pend_valid_q;
  assign in_stall_o = pend_valid_q;

  // --------------------------------------------------------------------------
  // Work out the actions of the incoming word and the state it leaves
  // --------------------------------------------------------------------------
  logic            start_ok;
  logic            act1, mode1, frame1, frame2;
  logic [NA_W-1:0] na1, na2;
  logic            in_mem, page_end;

  always_comb begin
    job_new      = '0;
    job_new.data = data_i;
    start_ok     = ({1'b0, address_i} < MEM_END);
    act1         = active_q;
    mode1        = mode_q;
    na1          = na_q;
    frame1       = frame_q;

    // New request: abandon any open frame, then start the new one if its address is in memory
    if (first_i) begin
      job_new.mask[SL_ABANDON]     = frame_q;
      job_new.mask[SL_ABANDON + 1] = frame_q && mode_q;
      act1   = start_ok;
      frame1 = start_ok && !mode_i;
      if (start_ok) begin
        mode1 = mode_i;
        na1   = {1'b0, address_i};
        job_new.mask[SL_WSTART +: 10] = {10{mode_i}};
        job_new.mask[SL_RSTART +: 4]  = {4{!mode_i}};
      end
    end

    job_new.addr = na1[23:0];
    in_mem   = act1 && (na1 < MEM_END);
    na2      = in_mem ? (na1 + NA_W'(1)) : na1;
    page_end = ((na2 & PAGE_MASK) == '0) || (na2 >= MEM_END);
    frame2   = frame1;

    if (in_mem) begin
      if (mode1) begin
        job_new.mask[SL_POPEN +: 6]      = {6{!frame1}};
        job_new.mask[SL_WDATA]           = 1'b1;
        job_new.mask[SL_PAGE_END +: 2]   = {2{page_end}};
        frame2 = !page_end;
      end else begin
        job_new.mask[SL_RECV] = 1'b1;
      end
    end

    active_d = act1;
    frame_d  = frame2;
    // Last word closes the request
    if (act1 && final_req_i) begin
      job_new.mask[SL_WCLOSE +: 2] = {2{mode1 && frame2}};
      job_new.mask[SL_WDIS +: 2]   = {2{mode1}};
      job_new.mask[SL_RCLOSE]      = !mode1 && frame2;
      active_d = 1'b0;
      frame_d  = 1'b0;
    end
    mode_d = mode1;
    na_d   = na2;
  end

  // --------------------------------------------------------------------------
  // Emitter: lowest pending slot goes out first
  // --------------------------------------------------------------------------
  logic [SLOT_IDX_W-1:0] sel;
  logic [SLOTS-1:0]      rest;
  logic                  out_free, emit, take_pend;
  slot_t                 sl;
  logic [7:0]            byte_d;

  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        sel = SLOT_IDX_W'(i);
      end
    end
  end

  assign rest      = cur_mask_q & ~(SLOTS'(1) << sel);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = out_free && (cur_mask_q != '0);
  assign take_pend = pend_valid_q && ((cur_mask_q == '0) || (emit && (rest == '0)));
  assign sl        = slot_info(sel);

  always_comb begin
    case (sl.src)
      SRC_CONST:    byte_d = sl.value;
      SRC_ADDR_HI:  byte_d = cur_addr_q[23:16];
      SRC_ADDR_MID: byte_d = cur_addr_q[15:8];
      SRC_ADDR_LO:  byte_d = cur_addr_q[7:0];
      SRC_DATA:     byte_d = cur_data_q;
      default:      byte_d = 8'h00;
    endcase
  end

  always_comb begin
    cur_mask_d = emit ? rest : cur_mask_q;
    if (take_pend) begin
      cur_mask_d = pend_q.mask;
    end
    pend_valid_d = pend_valid_q;
    if (take_pend) begin
      pend_valid_d = 1'b0;
    end
    // Words causing no action never enter the queue
    if (in_take && (job_new.mask != '0)) begin
      pend_valid_d = 1'b1;
    end
    out_valid_d = out_free ? emit : out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      na_q         <= '0;
      active_q     <= 1'b0;
      frame_q      <= 1'b0;
      mode_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      cur_mask_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        na_q     <= na_d;
        active_q <= active_d;
        frame_q  <= frame_d;
        mode_q   <= mode_d;
      end
      pend_valid_q <= pend_valid_d;
      cur_mask_q   <= cur_mask_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pend_q <= job_new;
    end
    if (take_pend) begin
      cur_addr_q <= pend_q.addr;
      cur_data_q <= pend_q.data;
    end
    if (emit) begin
      out_act_q  <= sl.action;
      out_byte_q <= (sl.action == ACT_SEND) ? byte_d : 8'h00;
      out_end_q  <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_act_q;
  assign byte_value_o = out_byte_q;
  assign run_end_o    = out_end_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPL(a_frame_in_req, clk_i, rst_ni, frame_q, active_q, "frame open outside request")
  `ASSERT_IMPL(a_addr_bound, clk_i, rst_ni, 1'b1, na_q <= MEM_END, "address past end of memory")
  `ASSERT_IMPL(a_pend_job, clk_i, rst_ni, pend_valid_q, pend_q.mask != '0, "empty job queued")
  `ASSERT_NEXT(a_emit_out, clk_i, rst_ni, emit, out_valid_o, "emitted action lost")

endmodule
